@@ design/bdsm_pkg.sv @@
// Shared types and constants for the bounded deque with search and min/max.
`timescale 1ns / 1ps

package bdsm_pkg;

   // Width of one stored word
   localparam int WORD_W = 32;

   // Action codes of an input item
   typedef enum logic [2:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_SEARCH     = 3'd4,
      ACT_MIN        = 3'd5,
      ACT_MAX        = 3'd6,
      ACT_REVERSE    = 3'd7
   } action_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Scan sequencer states
   typedef enum logic {
      SCAN_IDLE = 1'b0,
      SCAN_RUN  = 1'b1
   } scan_state_type;

   // Scan completion: pulse plus the values to report
   typedef struct packed {
      logic              fin;
      logic              found;
      logic [WORD_W-1:0] value;
   } scan_rsp_type;

endpackage

@@ design/bdsm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bdsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/bdsm_scan.sv @@
// Scan sequencer: walks the held entries through one shared compare unit.
`timescale 1ns / 1ps

module bdsm_scan #(
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  bdsm_pkg::action_type              op,
   input  logic signed [bdsm_pkg::WORD_W-1:0] key,
   input  logic [$clog2(DEPTH)-1:0]          front,
   input  logic [$clog2(DEPTH+1)-1:0]        count,
   input  logic signed [bdsm_pkg::WORD_W-1:0] rd_data,
   output logic                              busy,
   output logic                              rd_en,
   output logic [$clog2(DEPTH)-1:0]          rd_addr,
   output bdsm_pkg::scan_rsp_type            scan_rsp
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bdsm_pkg::scan_state_type state_ff, state_in;
   bdsm_pkg::action_type     op_ff;
   logic [IDX_W-1:0]         addr_ff, addr_in;
   logic [CNT_W-1:0]         left_ff, left_in;
   logic                     rd_vld_ff, last_ff, first_ff;
   logic                     found_ff, found_in;
   logic signed [bdsm_pkg::WORD_W-1:0] key_ff;
   logic signed [bdsm_pkg::WORD_W-1:0] acc_ff, acc_in;
   logic signed [bdsm_pkg::WORD_W-1:0] cmp_b;
   logic                     issue, fin, lt, eq, take;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bdsm_pkg::SCAN_IDLE: begin
            if (start) state_in = bdsm_pkg::SCAN_RUN;
         end
         bdsm_pkg::SCAN_RUN: begin
            if (fin) state_in = bdsm_pkg::SCAN_IDLE;
         end
         default: state_in = bdsm_pkg::SCAN_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      busy  = 1'b0;
      issue = 1'b0;
      fin   = 1'b0;
      case (state_ff)
         bdsm_pkg::SCAN_IDLE: begin
            busy = 1'b0;
         end
         bdsm_pkg::SCAN_RUN: begin
            busy  = 1'b1;
            issue = (left_ff != '0);
            fin   = rd_vld_ff & last_ff;
         end
         default: busy = 1'b0;
      endcase
   end

   assign rd_en   = issue;
   assign rd_addr = addr_ff;

   // Shared compare unit: key for search, running extreme otherwise
   always_comb begin
      cmp_b = (op_ff == bdsm_pkg::ACT_SEARCH) ? key_ff : acc_ff;
      lt    = (rd_data < cmp_b);
      eq    = (rd_data == cmp_b);
      take  = first_ff | ((op_ff == bdsm_pkg::ACT_MIN) ? lt : (~lt & ~eq));
   end

   // Accumulators and ring walk
   always_comb begin
      acc_in   = acc_ff;
      found_in = found_ff;
      if (rd_vld_ff) begin
         if (take) acc_in = rd_data;
         found_in = found_ff | eq;
      end
      addr_in = (addr_ff == IDX_W'(DEPTH - 1)) ? '0 : addr_ff + 1'b1;
      left_in = left_ff - 1'b1;
   end

   // Completion payload
   always_comb begin
      scan_rsp.fin   = fin;
      scan_rsp.found = (op_ff == bdsm_pkg::ACT_SEARCH) ? found_in : 1'b0;
      scan_rsp.value = (op_ff == bdsm_pkg::ACT_SEARCH) ? '0 : acc_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bdsm_pkg::SCAN_IDLE;
         rd_vld_ff <= 1'b0;
         left_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= issue;
         if (start) begin
            left_ff <= count;
         end else if (issue) begin
            left_ff <= left_in;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      last_ff <= issue & (left_ff == CNT_W'(1));
      if (start) begin
         addr_ff  <= front;
         op_ff    <= op;
         key_ff   <= key;
         first_ff <= 1'b1;
         found_ff <= 1'b0;
         acc_ff   <= '0;
      end else begin
         if (issue) addr_ff <= addr_in;
         if (rd_vld_ff) first_ff <= 1'b0;
         acc_ff   <= acc_in;
         found_ff <= found_in;
      end
   end

   // No read is issued once the last word has come back
   a_no_read_at_fin: assert property (@(posedge clock) disable iff (reset)
      fin |-> !rd_en)
      else $error("scan read issued after last word");

   // Sequencer drops out of run right after completion
   a_idle_after_fin: assert property (@(posedge clock) disable iff (reset)
      fin |=> !busy)
      else $error("scan still busy after completion");

   // A new scan is never started while one is running
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy)
      else $error("scan started while busy");

endmodule

@@ design/bounded_deque_search_minmax.sv @@
// Top level: bounded deque of signed words with search, minimum and maximum.
//
// Command channel: drive start with req_action and req_value; the item is
// taken at a rising edge where start is high and busy is low.
// Result channel: rsp_valid marks one cycle holding rsp_status, rsp_found,
// rsp_result_value and rsp_entry_count; the receiver takes it in that cycle
// and cannot hold it off.
// Push, pop and reverse, and any search/min/max on an empty store, finish
// without a scan: the result shows the cycle after acceptance and busy stays
// low, so a new item can follow every cycle.
// Search, min and max walk the held entries in ring order through one
// compare unit, one RAM read per cycle with registered read data: busy is
// high while the scan runs, until the last read word has been compared,
// and the result is registered from that completion; no new item is
// taken while busy is high.
// Reset clears the front pointer, count and orientation; the storage RAM
// is not cleared since only entries written by a push are ever read.

`timescale 1ns / 1ps

module bounded_deque_search_minmax #(
   parameter int DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [2:0]                         req_action,
   input  logic signed [bdsm_pkg::WORD_W-1:0] req_value,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_found,
   output logic signed [bdsm_pkg::WORD_W-1:0] rsp_result_value,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_entry_count
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   bdsm_pkg::action_type   act;
   bdsm_pkg::status_type   status;
   bdsm_pkg::scan_rsp_type scan_rsp;

   logic [IDX_W-1:0] front_ff, front_in, front_inc, front_dec, tail_slot, wr_addr;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rev_ff, rev_in;
   logic [SUM_W-1:0] tail_sum;
   logic             accept, full, empty, low_side, push_ok, scan_go, quick;
   logic             wr_en, rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic signed [bdsm_pkg::WORD_W-1:0] rd_data;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [1:0]                         rsp_status_ff;
   logic                               rsp_found_ff;
   logic signed [bdsm_pkg::WORD_W-1:0] rsp_value_ff;
   logic [CNT_W-1:0]                   rsp_count_ff;

   assign accept = start & ~busy;
   assign act    = bdsm_pkg::action_type'(req_action);

   // Ring pointer arithmetic
   always_comb begin
      full      = (cnt_ff == CNT_W'(DEPTH));
      empty     = (cnt_ff == '0);
      front_inc = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
      front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - 1'b1;
      tail_sum  = SUM_W'(front_ff) + SUM_W'(cnt_ff);
      if (tail_sum >= SUM_W'(DEPTH)) tail_sum = tail_sum - SUM_W'(DEPTH);
      tail_slot = tail_sum[IDX_W-1:0];
      low_side  = ((act == bdsm_pkg::ACT_PUSH_FRONT) ||
                   (act == bdsm_pkg::ACT_POP_FRONT)) ^ rev_ff;
      wr_addr   = low_side ? front_dec : tail_slot;
   end

   // Action decode
   always_comb begin
      front_in = front_ff;
      cnt_in   = cnt_ff;
      rev_in   = rev_ff;
      status   = bdsm_pkg::ST_OK;
      push_ok  = 1'b0;
      scan_go  = 1'b0;
      case (act)
         bdsm_pkg::ACT_PUSH_FRONT, bdsm_pkg::ACT_PUSH_BACK: begin
            if (full) begin
               status = bdsm_pkg::ST_FULL;
            end else begin
               push_ok = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
               if (low_side) front_in = front_dec;
            end
         end
         bdsm_pkg::ACT_POP_FRONT, bdsm_pkg::ACT_POP_BACK: begin
            if (empty) begin
               status = bdsm_pkg::ST_EMPTY;
            end else begin
               cnt_in = cnt_ff - 1'b1;
               if (low_side) front_in = front_inc;
            end
         end
         bdsm_pkg::ACT_SEARCH, bdsm_pkg::ACT_MIN, bdsm_pkg::ACT_MAX: begin
            if (empty) status = bdsm_pkg::ST_EMPTY;
            else       scan_go = 1'b1;
         end
         bdsm_pkg::ACT_REVERSE: begin
            rev_in = ~rev_ff;
         end
         default: begin
            status = bdsm_pkg::ST_OK;
         end
      endcase
   end

   assign wr_en        = accept & push_ok;
   assign quick        = accept & ~scan_go;
   assign rsp_valid_in = quick | scan_rsp.fin;

   // Deque state
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         cnt_ff       <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            front_ff <= front_in;
            cnt_ff   <= cnt_in;
            rev_ff   <= rev_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (quick) begin
         rsp_status_ff <= status;
         rsp_found_ff  <= 1'b0;
         rsp_value_ff  <= '0;
         rsp_count_ff  <= cnt_in;
      end else if (scan_rsp.fin) begin
         rsp_status_ff <= bdsm_pkg::ST_OK;
         rsp_found_ff  <= scan_rsp.found;
         rsp_value_ff  <= scan_rsp.value;
         rsp_count_ff  <= cnt_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_entry_count  = rsp_count_ff;

   // Entry storage
   bdsm_ram #(
      .WIDTH (bdsm_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Search / min / max sequencer
   bdsm_scan #(
      .DEPTH (DEPTH)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (accept & scan_go),
      .op       (act),
      .key      (req_value),
      .front    (front_ff),
      .count    (cnt_ff),
      .rd_data  (rd_data),
      .busy     (busy),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .scan_rsp (scan_rsp)
   );

   // A refused push is only reported with the store full
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bdsm_pkg::ST_FULL) |->
         (rsp_entry_count == CNT_W'(DEPTH)))
      else $error("full status with store not full");

   // Every result strobe follows a quick item or a scan completion
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(quick) || $past(scan_rsp.fin)))
      else $error("result strobe without a source");

   // The store is never written while a scan walks it
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      busy |-> !wr_en)
      else $error("store written during a scan");

endmodule
